FILE: src/lqs_pkg.sv
`timescale 1ns / 1ps

package lqs_pkg;

    // Command codes
    localparam logic [2:0] CMD_ENQUEUE  = 3'd0;
    localparam logic [2:0] CMD_DEQUEUE  = 3'd1;
    localparam logic [2:0] CMD_SEARCH   = 3'd2;
    localparam logic [2:0] CMD_RETRIEVE = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_BOUNDS    = 3'd4;

    // Slot index as carried along the chain; the position field fixes 8 bits
    localparam int IDX_W = 8;
    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] data_in;
        logic signed [31:0] search_key;
        logic [7:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic               found;
        logic signed [31:0] read_data;
        logic               is_empty;
    } t_out_item;

    // Probe that walks the cell chain for search and retrieve
    typedef struct packed {
        logic               valid;
        logic               is_search;
        logic               hit;
        logic signed [31:0] key;
        logic signed [31:0] data;
        t_idx               slot;
        t_idx               head;
        t_idx               fill;
    } t_probe;

    // Write bundle broadcast to all cells
    typedef struct packed {
        logic               en;
        t_idx               idx;
        logic signed [31:0] data;
    } t_wr;

endpackage

FILE: src/linear_array_queue_with_search_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Signals
// input     in         i_in_valid / o_in_ready, i_in_item (lqs_pkg::t_in_item)
// output    out        o_out_valid / i_out_ready, o_out_item (lqs_pkg::t_out_item)
//
// Enqueue, dequeue, clear, unknown and failing commands send no probe; their
// result is registered in the cycle after accept. Search and retrieve send a
// probe down the row of DEPTH cells, one cell per cycle, to a pending register.
// One item is in work at a time; the output register lets the next item in
// while a result is being taken.
// Synchronous active-low reset clears head, fill and handshake state; the
// entry cells are not cleared.
// A stalled search or retrieve result waits in a holding register until the output side is free.

module linear_array_queue_with_search_top #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lqs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lqs_pkg::t_out_item o_out_item
);

    localparam int IW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] FULL_CNT = IW'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [IW-1:0]      r_head, n_head;
    logic [IW-1:0]      r_fill, n_fill;
    lqs_pkg::t_probe    r_launch, n_launch;
    logic               r_out_valid, n_out_valid;
    lqs_pkg::t_out_item r_out, n_out;
    lqs_pkg::t_out_item r_pend, n_pend;
    lqs_pkg::t_wr       w_wr;

    lqs_pkg::t_probe    probes [DEPTH+1];

    logic               accept;
    logic               empty;
    logic [IW-1:0]      live_cnt;
    lqs_pkg::t_out_item res;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign empty      = (r_head >= r_fill);
    assign live_cnt   = empty ? '0 : (r_fill - r_head);

    // Command decode and sequencing
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_fill        = r_fill;
        n_launch      = r_launch;
        n_launch.valid = 1'b0;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        n_pend        = r_pend;
        w_wr.en       = 1'b0;
        w_wr.idx      = lqs_pkg::t_idx'(r_fill);
        w_wr.data     = i_in_item.data_in;
        res           = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_item.cmd)
                        lqs_pkg::CMD_ENQUEUE: begin
                            if (r_fill == FULL_CNT) begin
                                res.status = lqs_pkg::ST_OVERFLOW;
                            end else begin
                                w_wr.en = 1'b1;
                                n_fill  = r_fill + 1'b1;
                            end
                        end
                        lqs_pkg::CMD_DEQUEUE: begin
                            if (empty) begin
                                res.status = lqs_pkg::ST_UNDERFLOW;
                            end else begin
                                n_head = r_head + 1'b1;
                            end
                        end
                        lqs_pkg::CMD_SEARCH: begin
                            if (empty) begin
                                res.status = lqs_pkg::ST_EMPTY;
                            end else begin
                                n_launch.valid     = 1'b1;
                                n_launch.is_search = 1'b1;
                                n_state            = S_BUSY;
                            end
                        end
                        lqs_pkg::CMD_RETRIEVE: begin
                            if ((i_in_item.position == 8'd0) ||
                                (i_in_item.position > lqs_pkg::t_idx'(live_cnt))) begin
                                res.status = lqs_pkg::ST_BOUNDS;
                            end else begin
                                n_launch.valid     = 1'b1;
                                n_launch.is_search = 1'b0;
                                n_state            = S_BUSY;
                            end
                        end
                        lqs_pkg::CMD_CLEAR: begin
                            if (!empty) begin
                                n_head = r_fill;
                            end
                        end
                        default: begin
                        end
                    endcase

                    n_launch.hit  = 1'b0;
                    n_launch.key  = i_in_item.search_key;
                    n_launch.data = '0;
                    n_launch.slot = lqs_pkg::t_idx'(r_head) + i_in_item.position - 8'd1;
                    n_launch.head = lqs_pkg::t_idx'(r_head);
                    n_launch.fill = lqs_pkg::t_idx'(r_fill);

                    res.is_empty = (n_head >= n_fill);
                    if (!n_launch.valid) begin
                        n_out       = res;
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_BUSY: begin
                // Probe leaves the last cell
                if (probes[DEPTH].valid) begin
                    n_pend.status    = lqs_pkg::ST_OK;
                    n_pend.found     = probes[DEPTH].hit;
                    n_pend.read_data = probes[DEPTH].is_search ? '0 : probes[DEPTH].data;
                    n_pend.is_empty  = empty;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_head         <= '0;
            r_fill         <= '0;
            r_launch.valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_launch    <= n_launch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    // Row of entry cells
    assign probes[0] = r_launch;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        lqs_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr),
            .i_probe (probes[g]),
            .o_probe (probes[g+1])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: src/lqs_cell.sv
`timescale 1ns / 1ps

module lqs_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lqs_pkg::t_wr    i_wr,
    input  lqs_pkg::t_probe i_probe,
    output lqs_pkg::t_probe o_probe
);

    localparam lqs_pkg::t_idx CELL_IDX = lqs_pkg::t_idx'(IDX);

    logic signed [31:0] r_entry;
    lqs_pkg::t_probe    r_probe;
    lqs_pkg::t_probe    n_probe;
    logic               live;

    // Cell is live when its slot lies in [head, fill)
    assign live = (CELL_IDX >= i_probe.head) && (CELL_IDX < i_probe.fill);

    // Probe update: flag a match, or pick up the addressed entry
    always_comb begin
        n_probe = i_probe;
        if (i_probe.valid) begin
            if (i_probe.is_search) begin
                if (live && (r_entry == i_probe.key)) begin
                    n_probe.hit = 1'b1;
                end
            end else if (i_probe.slot == CELL_IDX) begin
                n_probe.data = r_entry;
            end
        end
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == CELL_IDX)) begin
            r_entry <= i_wr.data;
        end
    end

    // Probe stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

FILE: src/lqs_checker.sv
`timescale 1ns / 1ps

module lqs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input lqs_pkg::t_out_item o_out_item
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Read data only comes with a good status and without a hit
    a_rdata_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.read_data != 32'sd0) |->
            (o_out_item.status == lqs_pkg::ST_OK) && !o_out_item.found)
        else $error("read data on failed or non-retrieve result");

    // A hit means a non-empty queue and a good status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.found |->
            (o_out_item.status == lqs_pkg::ST_OK) && !o_out_item.is_empty)
        else $error("found set on empty queue or bad status");

    // Underflow and empty search only happen on an empty queue
    a_empty_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_item.status == lqs_pkg::ST_UNDERFLOW) ||
                        (o_out_item.status == lqs_pkg::ST_EMPTY)) |->
            o_out_item.is_empty)
        else $error("empty status with live entries");

endmodule

bind linear_array_queue_with_search_top lqs_checker u_lqs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int QDEPTH = 16;
    localparam int STALL_PCT = 27;
    localparam int IDLE_LIMIT = 4000;
    localparam int PRINT_LIMIT = 40;

    // Codes the block has no operation for
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    lqs_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_ready;
    lqs_pkg::t_out_item o_out_item;

    // Shadow of the queue, updated on every accepted item
    logic signed [31:0] q_store [QDEPTH];
    logic [4:0]         q_head;
    logic [4:0]         q_fill;

    lqs_pkg::t_out_item pending_results[$];
    int        error_count;
    int        items_sent;
    int        results_seen;
    int        search_hits;
    int        overflow_count;
    int        idle_cycles;
    bit        no_stall;

    linear_array_queue_with_search_top #(
        .DEPTH(QDEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item(o_out_item)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= no_stall || ($urandom_range(99) >= STALL_PCT);
    end

    // Queue behavior for one command; updates the shadow state
    function automatic lqs_pkg::t_out_item compute_queue_result(input lqs_pkg::t_in_item it);
        lqs_pkg::t_out_item r;
        int        live;
        r = '0;
        live = (q_head < q_fill) ? int'(q_fill) - int'(q_head) : 0;
        case (it.cmd)
            lqs_pkg::CMD_ENQUEUE: begin
                if (q_fill >= QDEPTH) begin
                    r.status = lqs_pkg::ST_OVERFLOW;
                    overflow_count++;
                end else begin
                    q_store[q_fill] = it.data_in;
                    q_fill = q_fill + 5'd1;
                end
            end
            lqs_pkg::CMD_DEQUEUE: begin
                if (live == 0) r.status = lqs_pkg::ST_UNDERFLOW;
                else q_head = q_head + 5'd1;
            end
            lqs_pkg::CMD_SEARCH: begin
                if (live == 0) begin
                    r.status = lqs_pkg::ST_EMPTY;
                end else begin
                    for (int i = q_head; i < q_fill; i++)
                        if (q_store[i] == it.search_key) r.found = 1'b1;
                    if (r.found) search_hits++;
                end
            end
            lqs_pkg::CMD_RETRIEVE: begin
                if (it.position < 1 || int'(it.position) > live)
                    r.status = lqs_pkg::ST_BOUNDS;
                else r.read_data = q_store[int'(q_head) + int'(it.position) - 1];
            end
            lqs_pkg::CMD_CLEAR: begin
                if (live != 0) q_head = q_fill;
            end
            default: ;
        endcase
        r.is_empty = (q_head >= q_fill);
        return r;
    endfunction

    function automatic lqs_pkg::t_in_item make_cmd(input logic [2:0] c,
                                                   input logic signed [31:0] d,
                                                   input logic signed [31:0] k,
                                                   input logic [7:0] p);
        lqs_pkg::t_in_item it;
        it.cmd = c;
        it.data_in = d;
        it.search_key = k;
        it.position = p;
        return it;
    endfunction

    // Random command, mostly meaningful against the current contents
    function automatic lqs_pkg::t_in_item pick_command(input int enq_pm, input int deq_pm,
                                                       input int clr_pm);
        lqs_pkg::t_in_item it;
        int       r;
        int       s;
        int       live;
        it = make_cmd(lqs_pkg::CMD_SEARCH, $urandom, $urandom, 8'($urandom_range(255)));
        live = (q_head < q_fill) ? int'(q_fill) - int'(q_head) : 0;
        r = $urandom_range(999);
        s = $urandom_range(19);
        if (r < enq_pm) begin
            it.cmd = lqs_pkg::CMD_ENQUEUE;
            // duplicates make searches with several matches
            if (q_fill != 0 && s < 5) it.data_in = q_store[$urandom_range(q_fill - 1)];
        end else if (r < enq_pm + deq_pm) begin
            it.cmd = lqs_pkg::CMD_DEQUEUE;
        end else if (r < enq_pm + deq_pm + clr_pm) begin
            it.cmd = lqs_pkg::CMD_CLEAR;
        end else if (r < 600) begin
            it.cmd = lqs_pkg::CMD_SEARCH;
            if (s < 10 && live > 0)
                it.search_key = q_store[int'(q_head) + $urandom_range(live - 1)];
            else if (s < 14 && q_head > 0)
                it.search_key = q_store[$urandom_range(q_head - 1)];
        end else if (r < 950) begin
            it.cmd = lqs_pkg::CMD_RETRIEVE;
            if (s < 14 && live > 0) it.position = 8'($urandom_range(live, 1));
            else if (s < 17) it.position = s[0] ? 8'd0 : 8'(live + 1);
        end else begin
            it.cmd = 3'($urandom_range(7));
        end
        return it;
    endfunction

    // Send one item, then record its expected result once accepted
    task automatic send_item(input lqs_pkg::t_in_item it);
        while (!no_stall && $urandom_range(99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(compute_queue_result(it));
        items_sent++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (error_count < PRINT_LIMIT)
            $display("mismatch on result %0d, %s: expected %h, got %h",
                     results_seen, what, want, got);
        error_count++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        lqs_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", 32'd0, o_out_item.read_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_out_item.status));
                if (o_out_item.found !== want.found)
                    report_mismatch("found", 32'(want.found), 32'(o_out_item.found));
                if (o_out_item.read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, o_out_item.read_data);
                if (o_out_item.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(want.is_empty), 32'(o_out_item.is_empty));
            end
            results_seen++;
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("testbench: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Every command but enqueue on a fresh, empty queue
    task automatic test_empty_queue;
        send_item(make_cmd(lqs_pkg::CMD_DEQUEUE, $urandom, $urandom, 8'd1));
        send_item(make_cmd(lqs_pkg::CMD_SEARCH, $urandom, $urandom, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_RETRIEVE, $urandom, $urandom, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_RETRIEVE, $urandom, $urandom, 8'd1));
        send_item(make_cmd(lqs_pkg::CMD_RETRIEVE, $urandom, $urandom, 8'd255));
        send_item(make_cmd(lqs_pkg::CMD_CLEAR, $urandom, $urandom, 8'd0));
        send_item(make_cmd(CMD_SPARE_5, '1, '1, 8'd255));
        send_item(make_cmd(CMD_SPARE_6, '0, '0, 8'd0));
        send_item(make_cmd(CMD_SPARE_7, $urandom, $urandom, 8'($urandom_range(255))));
    endtask

    // Word extremes through enqueue, search and retrieve
    task automatic test_word_extremes;
        send_item(make_cmd(lqs_pkg::CMD_ENQUEUE, 32'sh8000_0000, '0, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_ENQUEUE, 32'sh7fff_ffff, '0, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_ENQUEUE, 32'sd0, '1, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_ENQUEUE, -32'sd1, '0, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_SEARCH, '0, 32'sh8000_0000, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_SEARCH, '0, 32'sh7fff_ffff, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_SEARCH, '0, 32'sh1234_5678, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_RETRIEVE, '0, '0, 8'd1));
        send_item(make_cmd(lqs_pkg::CMD_RETRIEVE, '0, '0, 8'd4));
        send_item(make_cmd(lqs_pkg::CMD_RETRIEVE, '0, '0, 8'd5));
        send_item(make_cmd(lqs_pkg::CMD_DEQUEUE, '0, '0, 8'd0));
        // the dequeued word sits in front of the head and must not match
        send_item(make_cmd(lqs_pkg::CMD_SEARCH, '0, 32'sh8000_0000, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_RETRIEVE, '0, '0, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_RETRIEVE, '0, '0, 8'd3));
    endtask

    // Slow growth of the array so search and retrieve see many fill levels
    task automatic test_random_growth;
        for (int n = 0; n < 1000; n++) begin
            no_stall = (n >= 300 && n < 500);
            send_item(pick_command(15, 10, 2));
        end
        no_stall = 1'b0;
    endtask

    // Fill every slot, then enqueue with and without room in front
    task automatic test_full_array;
        while (q_fill < QDEPTH)
            send_item(make_cmd(lqs_pkg::CMD_ENQUEUE, $urandom, '0, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_ENQUEUE, $urandom, '0, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_DEQUEUE, '0, '0, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_ENQUEUE, $urandom, '0, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_SEARCH, '0, q_store[QDEPTH-1], 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_RETRIEVE, '0, '0,
                           8'(int'(q_fill) - int'(q_head))));
    endtask

    // Drain the full array at random
    task automatic test_random_drain;
        for (int n = 0; n < 500; n++) send_item(pick_command(100, 40, 0));
    endtask

    // Clear, then every command once no slot can be reused
    task automatic test_clear_exhausted;
        send_item(make_cmd(lqs_pkg::CMD_CLEAR, '0, '0, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_ENQUEUE, $urandom, '0, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_SEARCH, '0, q_store[QDEPTH-1], 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_RETRIEVE, '0, '0, 8'd1));
        send_item(make_cmd(lqs_pkg::CMD_DEQUEUE, '0, '0, 8'd0));
        send_item(make_cmd(lqs_pkg::CMD_CLEAR, '0, '0, 8'd0));
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        q_head = '0;
        q_fill = '0;
        for (int i = 0; i < QDEPTH; i++) q_store[i] = '0;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        search_hits = 0;
        overflow_count = 0;
        no_stall = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_word_extremes();
        test_random_growth();
        test_full_array();
        test_random_drain();
        test_clear_exhausted();
        i_in_valid <= 1'b0;

        // let the last results drain
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (QDEPTH + 8) @(posedge i_clk);

        $display("run: %0d commands sent, %0d results checked, %0d mismatches",
                 items_sent, results_seen, error_count);
        $display("run: %0d searches hit a live entry, %0d enqueues overflowed",
                 search_hits, overflow_count);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
